// ===== design/sabi_pkg.sv =====
// package: shared types and constants for the segment and box intersection unit
package sabi_pkg;

  localparam int FRAC_BITS   = 10;
  localparam int FIX_W       = 32;
  localparam int NUM_LANES   = 4;
  localparam int NUMW        = FIX_W + FRAC_BITS;
  localparam int LANE_LAT    = NUMW + 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FIX_W-1:0] FIX_ZERO = '0;
  localparam logic [FIX_W-1:0] FIX_ONE  = FIX_W'(1) << FRAC_BITS;

  typedef enum logic {
    CMD_SEGMENT = 1'b0,
    CMD_BOX     = 1'b1
  } cmd_t;

  typedef logic signed [FIX_W-1:0] fix_t;

  typedef struct packed {
    fix_t p0x;
    fix_t p0y;
    fix_t p1x;
    fix_t p1y;
    fix_t q0x;
    fix_t q0y;
    fix_t q1x;
    fix_t q1y;
  } seg_pair_t;

  typedef struct packed {
    logic [NUM_LANES-1:0]            lane_on;
    seg_pair_t [NUM_LANES-1:0]       pair;
  } job_t;

endpackage

// ===== design/sabi_in_if.sv =====
// interface: query channel
interface sabi_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] p_start_x;
  logic [31:0] p_start_y;
  logic [31:0] p_end_x;
  logic [31:0] p_end_y;
  logic [31:0] q_a_x;
  logic [31:0] q_a_y;
  logic [31:0] q_b_x;
  logic [31:0] q_b_y;

  modport source (output valid, cmd, p_start_x, p_start_y, p_end_x, p_end_y,
                  q_a_x, q_a_y, q_b_x, q_b_y, input ready);
  modport sink   (input valid, cmd, p_start_x, p_start_y, p_end_x, p_end_y,
                  q_a_x, q_a_y, q_b_x, q_b_y, output ready);
endinterface

// ===== design/sabi_out_if.sv =====
// interface: result channel
interface sabi_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

// ===== design/sabi_front.sv =====
// front: classifies a query and expands it into per-lane segment pairs
module sabi_front (
  sabi_in_if.sink          in_ch,
  output logic             job_valid,
  input  logic             job_ready,
  output sabi_pkg::job_t   job
);
  import sabi_pkg::*;

  fix_t px0, py0, px1, py1, ax, ay, bx, by, rx, ly;

  assign px0 = fix_t'(in_ch.p_start_x);
  assign py0 = fix_t'(in_ch.p_start_y);
  assign px1 = fix_t'(in_ch.p_end_x);
  assign py1 = fix_t'(in_ch.p_end_y);
  assign ax  = fix_t'(in_ch.q_a_x);
  assign ay  = fix_t'(in_ch.q_a_y);
  assign bx  = fix_t'(in_ch.q_b_x);
  assign by  = fix_t'(in_ch.q_b_y);
  assign rx  = ax + bx;
  assign ly  = ay + by;

  assign job_valid   = in_ch.valid;
  assign in_ch.ready = job_ready;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      job.pair[i].p0x = px0;
      job.pair[i].p0y = py0;
      job.pair[i].p1x = px1;
      job.pair[i].p1y = py1;
    end
    unique case (cmd_t'(in_ch.cmd))
      CMD_SEGMENT: begin
        job.lane_on = NUM_LANES'(1);
        for (int i = 0; i < NUM_LANES; i++) begin
          job.pair[i].q0x = ax;
          job.pair[i].q0y = ay;
          job.pair[i].q1x = bx;
          job.pair[i].q1y = by;
        end
      end
      CMD_BOX: begin
        job.lane_on = '1;
        // top, right, bottom, left
        job.pair[0].q0x = ax; job.pair[0].q0y = ay; job.pair[0].q1x = rx; job.pair[0].q1y = ay;
        job.pair[1].q0x = rx; job.pair[1].q0y = ay; job.pair[1].q1x = rx; job.pair[1].q1y = ly;
        job.pair[2].q0x = rx; job.pair[2].q0y = ly; job.pair[2].q1x = ax; job.pair[2].q1y = ly;
        job.pair[3].q0x = ax; job.pair[3].q0y = ly; job.pair[3].q1x = ax; job.pair[3].q1y = ay;
      end
      default: begin
        job.lane_on = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
          job.pair[i].q0x = ax;
          job.pair[i].q0y = ay;
          job.pair[i].q1x = bx;
          job.pair[i].q1y = by;
        end
      end
    endcase
  end

endmodule

// ===== design/sabi_queue.sv =====
// queue: short job fifo between front and back
module sabi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sabi_pkg::job_t  wr_job,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sabi_pkg::job_t  rd_job
);
  import sabi_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              wr_en, rd_en;

  assign wr_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid & wr_ready;
  assign rd_en    = rd_valid & rd_ready;
  assign rd_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// ===== design/sabi_lane.sv =====
// lane: pipelined segment pair test with two restoring dividers
module sabi_lane (
  input  logic                clk,
  input  logic                en,
  input  logic                on,
  input  sabi_pkg::seg_pair_t pair,
  output logic                hit
);
  import sabi_pkg::*;

  // differences
  logic on1_r;
  fix_t v1x_r, v1y_r, v2x_r, v2y_r, dx_r, dy_r;
  // products
  logic on2_r;
  logic signed [2*FIX_W-1:0] prod_r [6];
  // cross products
  logic on3_r;
  fix_t c_r, n1_r, n2_r;
  // divider stages
  logic              ok_r   [NUMW+1];
  logic              nega_r [NUMW+1];
  logic              negb_r [NUMW+1];
  logic [FIX_W-1:0]  den_r  [NUMW+1];
  logic [FIX_W:0]    rema_r [NUMW+1];
  logic [FIX_W:0]    remb_r [NUMW+1];
  logic [NUMW-1:0]   dvda_r [NUMW+1];
  logic [NUMW-1:0]   dvdb_r [NUMW+1];
  logic [FIX_W-1:0]  quoa_r [NUMW+1];
  logic [FIX_W-1:0]  quob_r [NUMW+1];
  logic [FIX_W:0]    trya   [NUMW];
  logic [FIX_W:0]    tryb   [NUMW];
  logic [FIX_W-1:0]  absa, absb, absc;
  logic [FIX_W-1:0]  sa, sb;
  logic              hit_r;

  assign absa = n1_r[FIX_W-1] ? FIX_W'(-n1_r) : FIX_W'(n1_r);
  assign absb = n2_r[FIX_W-1] ? FIX_W'(-n2_r) : FIX_W'(n2_r);
  assign absc = c_r[FIX_W-1]  ? FIX_W'(-c_r)  : FIX_W'(c_r);

  always_comb begin
    for (int k = 0; k < NUMW; k++) begin
      trya[k] = {rema_r[k][FIX_W-1:0], dvda_r[k][NUMW-1]};
      tryb[k] = {remb_r[k][FIX_W-1:0], dvdb_r[k][NUMW-1]};
    end
  end

  assign sa  = nega_r[NUMW] ? -quoa_r[NUMW] : quoa_r[NUMW];
  assign sb  = negb_r[NUMW] ? -quob_r[NUMW] : quob_r[NUMW];
  assign hit = hit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      on1_r <= on;
      v1x_r <= pair.p1x - pair.p0x;
      v1y_r <= pair.p1y - pair.p0y;
      v2x_r <= pair.q1x - pair.q0x;
      v2y_r <= pair.q1y - pair.q0y;
      dx_r  <= pair.q0x - pair.p0x;
      dy_r  <= pair.q0y - pair.p0y;

      on2_r     <= on1_r;
      prod_r[0] <= v1x_r * v2y_r;
      prod_r[1] <= v1y_r * v2x_r;
      prod_r[2] <= dx_r * v2y_r;
      prod_r[3] <= dy_r * v2x_r;
      prod_r[4] <= v1x_r * dy_r;
      prod_r[5] <= v1y_r * dx_r;

      on3_r <= on2_r;
      c_r   <= prod_r[0][FRAC_BITS +: FIX_W] - prod_r[1][FRAC_BITS +: FIX_W];
      n1_r  <= prod_r[2][FRAC_BITS +: FIX_W] - prod_r[3][FRAC_BITS +: FIX_W];
      n2_r  <= prod_r[5][FRAC_BITS +: FIX_W] - prod_r[4][FRAC_BITS +: FIX_W];

      ok_r[0]   <= on3_r & (c_r != '0);
      nega_r[0] <= n1_r[FIX_W-1] ^ c_r[FIX_W-1];
      negb_r[0] <= n2_r[FIX_W-1] ^ c_r[FIX_W-1];
      den_r[0]  <= absc;
      rema_r[0] <= '0;
      remb_r[0] <= '0;
      dvda_r[0] <= NUMW'(absa) << FRAC_BITS;
      dvdb_r[0] <= NUMW'(absb) << FRAC_BITS;
      quoa_r[0] <= '0;
      quob_r[0] <= '0;

      for (int k = 0; k < NUMW; k++) begin
        ok_r[k+1]   <= ok_r[k];
        nega_r[k+1] <= nega_r[k];
        negb_r[k+1] <= negb_r[k];
        den_r[k+1]  <= den_r[k];
        dvda_r[k+1] <= dvda_r[k] << 1;
        dvdb_r[k+1] <= dvdb_r[k] << 1;
        if (trya[k] >= {1'b0, den_r[k]}) begin
          rema_r[k+1] <= trya[k] - {1'b0, den_r[k]};
          quoa_r[k+1] <= {quoa_r[k][FIX_W-2:0], 1'b1};
        end else begin
          rema_r[k+1] <= trya[k];
          quoa_r[k+1] <= {quoa_r[k][FIX_W-2:0], 1'b0};
        end
        if (tryb[k] >= {1'b0, den_r[k]}) begin
          remb_r[k+1] <= tryb[k] - {1'b0, den_r[k]};
          quob_r[k+1] <= {quob_r[k][FIX_W-2:0], 1'b1};
        end else begin
          remb_r[k+1] <= tryb[k];
          quob_r[k+1] <= {quob_r[k][FIX_W-2:0], 1'b0};
        end
      end

      hit_r <= ok_r[NUMW] & ~sa[FIX_W-1] & (sa <= FIX_ONE)
                          & ~sb[FIX_W-1] & (sb <= FIX_ONE);
    end
  end

endmodule

// ===== design/sabi_back.sv =====
// back: four test lanes, valid tracking and result register
module sabi_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  sabi_pkg::job_t  job,
  sabi_out_if.source      out_ch
);
  import sabi_pkg::*;

  logic                 vld_r [LANE_LAT];
  logic [NUM_LANES-1:0] lane_hit;
  logic                 en;
  logic                 out_valid_r;
  logic                 hit_r;

  assign en        = ~out_valid_r | out_ch.ready;
  assign job_ready = en;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    sabi_lane u_lane (
      .clk  (clk),
      .en   (en),
      .on   (job.lane_on[i]),
      .pair (job.pair[i]),
      .hit  (lane_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= job_valid;
      for (int k = 1; k < LANE_LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= |lane_hit;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.hit   = hit_r;

endmodule

// ===== design/segment_and_box_intersect_unit.sv =====
// top level: segment against segment or box intersection unit
// Takes one query per cycle while the result channel does not stall and
// returns one hit bit per query, in order. A box query tests its four sides
// in four parallel lanes, so both commands keep that rate. A query may wait
// in the two-entry input queue, then passes the difference, product and cross
// product registers and the restoring dividers, which resolve one quotient bit
// per pipeline stage. While a result waits to be taken the whole back pipeline
// holds and the queue absorbs up to two more queries.
module segment_and_box_intersect_unit (
  input  logic       clk,
  input  logic       rst_n,
  sabi_in_if.sink    in_ch,
  sabi_out_if.source out_ch
);
  import sabi_pkg::*;

  logic fr_valid, fr_ready, bk_valid, bk_ready;
  job_t fr_job, bk_job;

  sabi_front u_front (
    .in_ch     (in_ch),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  sabi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_job   (fr_job),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_job   (bk_job)
  );

  sabi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/sabi_chk.sv =====
// checker: port-level assertions for the intersection unit
module sabi_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);
  logic [7:0] pend_r;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 8'(in_fire) - 8'(out_fire);
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> pend_r != 8'd0)
    else $error("result with no outstanding query");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit))
    else $error("hit changed while stalled");
endmodule

bind segment_and_box_intersect_unit sabi_chk u_sabi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit)
);
